@@ rtl/cdq_pkg.sv @@
//------------------------------------------------------------------------------
// cdq_pkg
// Shared widths, operation and status codes, and the control bundle that
// steers the storage cells of the circular deque.
//------------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;
	localparam int ADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [IDX_W-1:0] head;
		logic [IDX_W-1:0] tail;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/circular_deque_core.sv @@
//------------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue in a circular store with a configurable capacity.
//------------------------------------------------------------------------------
// Each input item (kind, value) is one operation: push back, push front,
// pop front, pop back or clear. Each item yields exactly one result item with
// the status, the front and back elements after the operation (-1 when
// empty), the element count and an empty flag.
// The indices and the count update in the cycle the item is accepted. The
// front and back elements then travel down the row of 16 storage cells, one
// cell per cycle, and the result is loaded from the last cell into the output
// register; the block takes no new item while one is still in that cell row.
// A new item is taken as soon as the previous one has left the cell row,
// even while its result still waits in the output register; if that result
// is still not taken when the next one is ready, the block holds.
// The capacity register sits at address 0 of the APB port, resets to 16 and
// is written by the user only while the block is idle; the block does not enforce it.
// Reset empties the deque and zeroes both indices; slots stay undefined until written.
//------------------------------------------------------------------------------
`default_nettype none

module circular_deque_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [cdq_pkg::ADDR_W-1:0]     paddr,
	input  wire  [cdq_pkg::PDATA_W-1:0]    pwdata,
	output logic [cdq_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [cdq_pkg::KIND_W-1:0]     kind,
	input  wire  [cdq_pkg::DATA_W-1:0]     value,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [cdq_pkg::STAT_W-1:0]     status,
	output logic [cdq_pkg::DATA_W-1:0]     front_value,
	output logic [cdq_pkg::DATA_W-1:0]     back_value,
	output logic [cdq_pkg::CNT_W-1:0]      count,
	output logic                           is_empty
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

	state_t                        state_q;
	logic [cdq_pkg::CNT_W-1:0]     cap_q;
	logic [cdq_pkg::IDX_W-1:0]     head_q;
	logic [cdq_pkg::IDX_W-1:0]     tail_q;
	logic [cdq_pkg::CNT_W-1:0]     fill_q;
	logic [cdq_pkg::CNT_W-1:0]     sweep_q;
	logic [cdq_pkg::STAT_W-1:0]    op_stat_q;

	logic                          out_valid_q;
	logic [cdq_pkg::STAT_W-1:0]    status_q;
	logic [cdq_pkg::DATA_W-1:0]    front_q;
	logic [cdq_pkg::DATA_W-1:0]    back_q;
	logic [cdq_pkg::CNT_W-1:0]     count_q;
	logic                          empty_q;

	logic                          cfg_wr;
	logic                          accept;
	logic                          load_out;
	logic [cdq_pkg::CNT_W-1:0]     cap_eff;
	logic [cdq_pkg::CNT_W-1:0]     head_inc;
	logic [cdq_pkg::CNT_W-1:0]     tail_inc;
	logic [cdq_pkg::IDX_W-1:0]     head_next_idx;
	logic [cdq_pkg::IDX_W-1:0]     head_prev_idx;
	logic [cdq_pkg::IDX_W-1:0]     tail_next_idx;
	logic [cdq_pkg::IDX_W-1:0]     tail_prev_idx;
	logic [cdq_pkg::IDX_W-1:0]     head_d;
	logic [cdq_pkg::IDX_W-1:0]     tail_d;
	logic [cdq_pkg::CNT_W-1:0]     fill_d;
	logic [cdq_pkg::STAT_W-1:0]    stat_d;
	logic                          wr_en_d;
	logic [cdq_pkg::IDX_W-1:0]     wr_idx_d;
	cdq_pkg::cell_ctrl_t           ctrl;

	logic [cdq_pkg::DATA_W-1:0]    front_chain [cdq_pkg::DEPTH+1];
	logic [cdq_pkg::DATA_W-1:0]    back_chain  [cdq_pkg::DEPTH+1];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == cdq_pkg::REG_CAPACITY);
	assign prdata = (paddr[2] == cdq_pkg::REG_CAPACITY)
		? cdq_pkg::PDATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cdq_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[cdq_pkg::CNT_W-1:0];
		end
	end

	// clamp capacity to 1..DEPTH
	always_comb begin
		priority if (cap_q == '0) begin
			cap_eff = cdq_pkg::CNT_W'(1);
		end else if (cap_q > cdq_pkg::CNT_W'(cdq_pkg::DEPTH)) begin
			cap_eff = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	// wrap forward at capacity, wrap back from 0 to capacity-1
	assign head_inc      = cdq_pkg::CNT_W'(head_q) + cdq_pkg::CNT_W'(1);
	assign tail_inc      = cdq_pkg::CNT_W'(tail_q) + cdq_pkg::CNT_W'(1);
	assign head_next_idx = (head_inc >= cap_eff) ? '0 : head_inc[cdq_pkg::IDX_W-1:0];
	assign tail_next_idx = (tail_inc >= cap_eff) ? '0 : tail_inc[cdq_pkg::IDX_W-1:0];
	assign head_prev_idx = (head_q == '0)
		? cdq_pkg::IDX_W'(cap_eff - cdq_pkg::CNT_W'(1)) : head_q - cdq_pkg::IDX_W'(1);
	assign tail_prev_idx = (tail_q == '0)
		? cdq_pkg::IDX_W'(cap_eff - cdq_pkg::CNT_W'(1)) : tail_q - cdq_pkg::IDX_W'(1);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		fill_d   = fill_q;
		stat_d   = cdq_pkg::STAT_DONE;
		wr_en_d  = 1'b0;
		wr_idx_d = '0;
		unique case (kind)
			cdq_pkg::KIND_PUSH_BACK, cdq_pkg::KIND_PUSH_FRONT: begin
				priority if (fill_q >= cap_eff) begin
					stat_d = cdq_pkg::STAT_FULL;
				end else if (fill_q == '0) begin
					head_d   = '0;
					tail_d   = '0;
					fill_d   = cdq_pkg::CNT_W'(1);
					wr_en_d  = 1'b1;
					wr_idx_d = '0;
				end else if (kind == cdq_pkg::KIND_PUSH_BACK) begin
					tail_d   = tail_next_idx;
					fill_d   = fill_q + cdq_pkg::CNT_W'(1);
					wr_en_d  = 1'b1;
					wr_idx_d = tail_next_idx;
				end else begin
					head_d   = head_prev_idx;
					fill_d   = fill_q + cdq_pkg::CNT_W'(1);
					wr_en_d  = 1'b1;
					wr_idx_d = head_prev_idx;
				end
			end
			cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK: begin
				if (fill_q == '0) begin
					stat_d = cdq_pkg::STAT_EMPTY;
				end else begin
					if (kind == cdq_pkg::KIND_POP_FRONT) begin
						head_d = head_next_idx;
					end else begin
						tail_d = tail_prev_idx;
					end
					fill_d = fill_q - cdq_pkg::CNT_W'(1);
				end
			end
			cdq_pkg::KIND_CLEAR: begin
				fill_d = '0;
			end
			default: begin
				// unknown kinds change nothing
			end
		endcase
	end

	// sequencing
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_SWEEP) && (sweep_q == cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
		&& (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			sweep_q   <= '0;
			op_stat_q <= cdq_pkg::STAT_DONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q    <= head_d;
						tail_q    <= tail_d;
						fill_q    <= fill_d;
						op_stat_q <= stat_d;
						sweep_q   <= '0;
						state_q   <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (sweep_q != cdq_pkg::CNT_W'(cdq_pkg::DEPTH)) begin
						sweep_q <= sweep_q + cdq_pkg::CNT_W'(1);
					end else if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// cell row
	assign ctrl.wr_en  = accept && wr_en_d;
	assign ctrl.wr_idx = wr_idx_d;
	assign ctrl.head   = head_q;
	assign ctrl.tail   = tail_q;

	assign front_chain[0] = '0;
	assign back_chain[0]  = '0;

	for (genvar g = 0; g < cdq_pkg::DEPTH; g++) begin : g_cell
		cdq_cell u_cell (
			.clk       (clk),
			.cell_idx  (cdq_pkg::IDX_W'(g)),
			.ctrl      (ctrl),
			.wr_data   (value),
			.front_in  (front_chain[g]),
			.back_in   (back_chain[g]),
			.front_out (front_chain[g+1]),
			.back_out  (back_chain[g+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= op_stat_q;
			count_q  <= fill_q;
			empty_q  <= (fill_q == '0);
			front_q  <= (fill_q == '0) ? '1 : front_chain[cdq_pkg::DEPTH];
			back_q   <= (fill_q == '0) ? '1 : back_chain[cdq_pkg::DEPTH];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign front_value = front_q;
	assign back_value  = back_q;
	assign count       = count_q;
	assign is_empty    = empty_q;

endmodule

`default_nettype wire

@@ rtl/cdq_cell.sv @@
//------------------------------------------------------------------------------
// cdq_cell
// One slot of the deque store. Holds its element and passes the front and
// back values along the row, replacing them with its own element when the
// head or tail index points at this slot.
//------------------------------------------------------------------------------
`default_nettype none

module cdq_cell (
	input  wire                            clk,
	input  wire  [cdq_pkg::IDX_W-1:0]      cell_idx,
	input  wire  cdq_pkg::cell_ctrl_t      ctrl,
	input  wire  [cdq_pkg::DATA_W-1:0]     wr_data,
	input  wire  [cdq_pkg::DATA_W-1:0]     front_in,
	input  wire  [cdq_pkg::DATA_W-1:0]     back_in,
	output logic [cdq_pkg::DATA_W-1:0]     front_out,
	output logic [cdq_pkg::DATA_W-1:0]     back_out
);

	logic [cdq_pkg::DATA_W-1:0] slot_q;
	logic [cdq_pkg::DATA_W-1:0] front_q;
	logic [cdq_pkg::DATA_W-1:0] back_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (ctrl.wr_idx == cell_idx)) begin
			slot_q <= wr_data;
		end
		front_q <= (ctrl.head == cell_idx) ? slot_q : front_in;
		back_q  <= (ctrl.tail == cell_idx) ? slot_q : back_in;
	end

	assign front_out = front_q;
	assign back_out  = back_q;

endmodule

`default_nettype wire
